### src/mf3rgb_pkg.sv
// Package for the 3x3 RGB median filter: pixel type, register indexes,
// field widths and the small min/max/median helpers shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package mf3rgb_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic valid;
        logic need_med;
        logic need_bdr;
    } job_flags_t;

    typedef struct packed {
        logic take;
        logic clear_med;
    } job_ack_t;

    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 4096;

    localparam int CHAN_W         = 8;
    localparam int PIXEL_W        = 3 * CHAN_W;
    localparam int NB_COUNT       = 9;
    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int OUT_COL_W      = 10;
    localparam int OUT_ROW_W      = 12;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = IMAGE_HEIGHT_W;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam int S_TDATA_W     = PIXEL_W;
    localparam int OUT_FIELDS_W  = PIXEL_W + OUT_COL_W + OUT_ROW_W;
    localparam int M_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_PAD_W = M_TDATA_W - OUT_FIELDS_W;

    function automatic logic [CHAN_W-1:0] min2(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [CHAN_W-1:0] max2(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [CHAN_W-1:0] min3(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b,
                                               input logic [CHAN_W-1:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [CHAN_W-1:0] max3(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b,
                                               input logic [CHAN_W-1:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [CHAN_W-1:0] med3(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b,
                                               input logic [CHAN_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

### src/mf3rgb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for both line stores. No dependencies.
`timescale 1ns / 1ps

module mf3rgb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/mf3rgb_median.sv
// Per-channel median of a 3x3 neighborhood of RGB pixels, combinational.
// Depends on mf3rgb_pkg for the pixel type and the min/max/median helpers.
`timescale 1ns / 1ps

module mf3rgb_median (
    input  mf3rgb_pkg::rgb_t [mf3rgb_pkg::NB_COUNT-1:0] nb,
    output mf3rgb_pkg::rgb_t                            med
);

    wire [mf3rgb_pkg::PIXEL_W-1:0] med_bits;

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [mf3rgb_pkg::CHAN_W-1:0] lo  [3];
        logic [mf3rgb_pkg::CHAN_W-1:0] mid [3];
        logic [mf3rgb_pkg::CHAN_W-1:0] hi  [3];

        for (genvar k = 0; k < 3; k++) begin : g_col
            logic [mf3rgb_pkg::CHAN_W-1:0] a;
            logic [mf3rgb_pkg::CHAN_W-1:0] b;
            logic [mf3rgb_pkg::CHAN_W-1:0] c;

            assign a      = nb[3*k][mf3rgb_pkg::CHAN_W*ch +: mf3rgb_pkg::CHAN_W];
            assign b      = nb[3*k+1][mf3rgb_pkg::CHAN_W*ch +: mf3rgb_pkg::CHAN_W];
            assign c      = nb[3*k+2][mf3rgb_pkg::CHAN_W*ch +: mf3rgb_pkg::CHAN_W];
            assign lo[k]  = mf3rgb_pkg::min3(a, b, c);
            assign mid[k] = mf3rgb_pkg::med3(a, b, c);
            assign hi[k]  = mf3rgb_pkg::max3(a, b, c);
        end

        // The median of nine is the median of the largest column minimum,
        // the median of the column medians and the smallest column maximum.
        assign med_bits[mf3rgb_pkg::CHAN_W*ch +: mf3rgb_pkg::CHAN_W] =
            mf3rgb_pkg::med3(mf3rgb_pkg::max3(lo[0], lo[1], lo[2]),
                             mf3rgb_pkg::med3(mid[0], mid[1], mid[2]),
                             mf3rgb_pkg::min3(hi[0], hi[1], hi[2]));
    end

    assign med = mf3rgb_pkg::rgb_t'(med_bits);

endmodule

### src/mf3rgb_front.sv
// Input side of the median filter: frame size registers, raster counters,
// line stores, the 3x3 window and the job register handed to the output stage.
// Depends on mf3rgb_pkg and mf3rgb_ram.
`timescale 1ns / 1ps

module mf3rgb_front #(
    parameter int MAX_WIDTH  = mf3rgb_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3rgb_pkg::DEFAULT_MAX_HEIGHT,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [mf3rgb_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [mf3rgb_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [mf3rgb_pkg::S_TDATA_W-1:0]            s_tdata,
    input  mf3rgb_pkg::job_ack_t                        job_ack,
    output mf3rgb_pkg::job_flags_t                      job_flags,
    output mf3rgb_pkg::rgb_t [mf3rgb_pkg::NB_COUNT-1:0] job_nb,
    output logic [COL_W-1:0]                            job_col,
    output logic [ROW_W-1:0]                            job_row
);

    localparam int W_RESET_EFF = (mf3rgb_pkg::WIDTH_RESET < MAX_WIDTH) ?
                                 mf3rgb_pkg::WIDTH_RESET : MAX_WIDTH;
    localparam int H_RESET_EFF = (mf3rgb_pkg::HEIGHT_RESET < MAX_HEIGHT) ?
                                 mf3rgb_pkg::HEIGHT_RESET : MAX_HEIGHT;
    localparam logic [COL_W-1:0] COL_LAST_RESET = COL_W'(W_RESET_EFF - 1);
    localparam logic [ROW_W-1:0] ROW_LAST_RESET = ROW_W'(H_RESET_EFF - 1);

    logic                   accept;
    logic                   cfg_width_wr;
    logic                   cfg_height_wr;
    logic                   cfg_restart;
    logic [COL_W-1:0]       col_last_cfg;
    logic [ROW_W-1:0]       row_last_cfg;
    logic [COL_W-1:0]       col_last_reg, col_last_next;
    logic [ROW_W-1:0]       row_last_reg, row_last_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    mf3rgb_pkg::rgb_t       cur;
    mf3rgb_pkg::rgb_t       up1;
    mf3rgb_pkg::rgb_t       up2;
    mf3rgb_pkg::rgb_t       win_reg [6];
    logic                   take_med;
    logic                   take_bdr;
    mf3rgb_pkg::job_flags_t flags_reg, flags_next;
    mf3rgb_pkg::rgb_t [mf3rgb_pkg::NB_COUNT-1:0] nb_reg;
    logic [COL_W-1:0]       jcol_reg;
    logic [ROW_W-1:0]       jrow_reg;

    assign cfg_ready     = 1'b1;
    assign cfg_width_wr  = cfg_valid && (cfg_index == mf3rgb_pkg::REG_IMAGE_WIDTH);
    assign cfg_height_wr = cfg_valid && (cfg_index == mf3rgb_pkg::REG_IMAGE_HEIGHT);
    assign cfg_restart   = cfg_width_wr || cfg_height_wr;

    assign s_tready = !flags_reg.valid || job_ack.take;
    assign accept   = s_tvalid && s_tready;

    assign cur = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    // Out-of-range sizes are clamped to 1..MAX on write.
    always_comb begin
        int w_eff;
        int h_eff;
        w_eff = int'(cfg_data[mf3rgb_pkg::IMAGE_WIDTH_W-1:0]);
        h_eff = int'(cfg_data[mf3rgb_pkg::IMAGE_HEIGHT_W-1:0]);
        if (w_eff < 1) begin
            w_eff = 1;
        end
        if (w_eff > MAX_WIDTH) begin
            w_eff = MAX_WIDTH;
        end
        if (h_eff < 1) begin
            h_eff = 1;
        end
        if (h_eff > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
        end
        col_last_cfg = COL_W'(w_eff - 1);
        row_last_cfg = ROW_W'(h_eff - 1);
    end

    always_comb begin
        col_last_next = cfg_width_wr  ? col_last_cfg : col_last_reg;
        row_last_next = cfg_height_wr ? row_last_cfg : row_last_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (cfg_restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_reg == col_last_reg) begin
                col_next = '0;
                row_next = (row_reg == row_last_reg) ? '0 : ROW_W'(row_reg + 1'b1);
            end else begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
    end

    // The read address runs one pixel ahead, so the registered read data
    // is ready when the pixel of that column arrives.
    mf3rgb_ram #(
        .WIDTH (mf3rgb_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (cur),
        .raddr (col_next),
        .rdata (up1)
    );

    mf3rgb_ram #(
        .WIDTH (mf3rgb_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (up1),
        .raddr (col_next),
        .rdata (up2)
    );

    assign take_med = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign take_bdr = (row_reg == '0) || (row_reg == row_last_reg) ||
                      (col_reg == '0) || (col_reg == col_last_reg);

    always_comb begin
        flags_next = flags_reg;
        if (accept) begin
            flags_next.valid    = take_med || take_bdr;
            flags_next.need_med = take_med;
            flags_next.need_bdr = take_bdr;
        end else if (job_ack.take) begin
            flags_next.valid = 1'b0;
        end else if (job_ack.clear_med) begin
            flags_next.need_med = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_last_reg <= COL_LAST_RESET;
            row_last_reg <= ROW_LAST_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            flags_reg    <= '0;
        end else begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            flags_reg    <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= up2;
            win_reg[1] <= up1;
            win_reg[2] <= cur;
            nb_reg[0]  <= win_reg[3];
            nb_reg[1]  <= win_reg[4];
            nb_reg[2]  <= win_reg[5];
            nb_reg[3]  <= win_reg[0];
            nb_reg[4]  <= win_reg[1];
            nb_reg[5]  <= win_reg[2];
            nb_reg[6]  <= up2;
            nb_reg[7]  <= up1;
            nb_reg[8]  <= cur;
            jcol_reg   <= col_reg;
            jrow_reg   <= row_reg;
        end
    end

    assign job_flags = flags_reg;
    assign job_nb    = nb_reg;
    assign job_col   = jcol_reg;
    assign job_row   = jrow_reg;

endmodule

### src/median_filter_3x3_rgb_unit.sv
// Top level of the 3x3 RGB median filter: input side, median network and
// the output register. Depends on mf3rgb_pkg, mf3rgb_front and mf3rgb_median.
//
// The block takes one RGB pixel per beat in raster order and accepts a new
// pixel every clock unless the output stalls. A border pixel is passed through
// unchanged with its coordinates and tuser low; once the 3x3 window around an
// interior pixel is complete, that pixel's per-channel median leaves with tuser
// high. A border pixel completing a window gives two beats, the median first,
// and holds the input until the second is loaded, since the single output
// register moves at most one result per clock. Results pass the job register,
// then the output register. Writing the width or height register restarts the
// frame at row 0, column 0; line stores need no clearing after reset.
`timescale 1ns / 1ps

module median_filter_3x3_rgb_unit #(
    parameter int MAX_WIDTH  = mf3rgb_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3rgb_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mf3rgb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mf3rgb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata from bit 0: red, green, blue.
    input  logic [mf3rgb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata from bit 0: out_red, out_green, out_blue, out_col, out_row, zeros.
    output logic [mf3rgb_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: is_median.
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    mf3rgb_pkg::job_flags_t                      job_flags;
    mf3rgb_pkg::job_ack_t                        job_ack;
    mf3rgb_pkg::rgb_t [mf3rgb_pkg::NB_COUNT-1:0] job_nb;
    logic [COL_W-1:0]                            job_col;
    logic [ROW_W-1:0]                            job_row;
    mf3rgb_pkg::rgb_t                            med;
    logic                                        out_load;

    logic                                  m_valid_reg, m_valid_next;
    mf3rgb_pkg::rgb_t                      pix_reg, pix_next;
    logic [mf3rgb_pkg::OUT_COL_W-1:0]      ocol_reg, ocol_next;
    logic [mf3rgb_pkg::OUT_ROW_W-1:0]      orow_reg, orow_next;
    logic                                  is_med_reg, is_med_next;
    logic                                  last_reg, last_next;

    mf3rgb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_ack   (job_ack),
        .job_flags (job_flags),
        .job_nb    (job_nb),
        .job_col   (job_col),
        .job_row   (job_row)
    );

    mf3rgb_median u_median (
        .nb  (job_nb),
        .med (med)
    );

    assign out_load = job_flags.valid && (!m_valid_reg || m_tready);

    always_comb begin
        job_ack.take      = 1'b0;
        job_ack.clear_med = 1'b0;
        m_valid_next      = m_valid_reg && !m_tready;
        pix_next          = pix_reg;
        ocol_next         = ocol_reg;
        orow_next         = orow_reg;
        is_med_next       = is_med_reg;
        last_next         = last_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            if (job_flags.need_med) begin
                pix_next          = med;
                ocol_next         = mf3rgb_pkg::OUT_COL_W'(COL_W'(job_col - 1'b1));
                orow_next         = mf3rgb_pkg::OUT_ROW_W'(ROW_W'(job_row - 1'b1));
                is_med_next       = 1'b1;
                last_next         = !job_flags.need_bdr;
                job_ack.take      = !job_flags.need_bdr;
                job_ack.clear_med = job_flags.need_bdr;
            end else begin
                pix_next     = job_nb[mf3rgb_pkg::NB_COUNT-1];
                ocol_next    = mf3rgb_pkg::OUT_COL_W'(job_col);
                orow_next    = mf3rgb_pkg::OUT_ROW_W'(job_row);
                is_med_next  = 1'b0;
                last_next    = 1'b1;
                job_ack.take = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg    <= pix_next;
        ocol_reg   <= ocol_next;
        orow_reg   <= orow_next;
        is_med_reg <= is_med_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{mf3rgb_pkg::M_TDATA_PAD_W{1'b0}}, orow_reg, ocol_reg,
                       pix_reg.blue, pix_reg.green, pix_reg.red};
    assign m_tuser  = is_med_reg;
    assign m_tlast  = last_reg;

endmodule
